>>> src/ppr_forward_push_engine_defines.svh
// Assertion macros shared by the checker of the forward push engine.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef PPR_FORWARD_PUSH_ENGINE_DEFINES_SVH
`define PPR_FORWARD_PUSH_ENGINE_DEFINES_SVH
// same-cycle implication
`define PPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> src/ppr_pkg.sv
// Shared constants, codes and the vertex word type of the forward push engine.
// Depends on nothing.
`default_nettype none
package ppr_pkg;
	localparam int VERTICES  = 1024;
	localparam int EDGES     = 8192;
	localparam int VALUE_W   = 40;
	localparam int POS_W     = VALUE_W - 1;
	localparam int VIDX_W    = $clog2(VERTICES);
	localparam int EIDX_W    = $clog2(EDGES);
	localparam int SLOT_W    = EIDX_W + 1;
	localparam int CNT_W     = VIDX_W + 1;
	localparam int INV_W     = 17;
	localparam int PIECE_W   = INV_W;
	localparam int COEF_W    = 3 * PIECE_W;
	localparam int C_W       = 2 * INV_W - 1;
	localparam int ONE_Q16   = 65536;
	localparam int ALPHA_SH  = 16;
	localparam int EDGE_SH   = 48;
	localparam int POP_LIMIT = VERTICES * 16;
	localparam int RUNP_W    = $clog2(POP_LIMIT + 1);
	localparam int POPS_W    = 32;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic [ACT_W-1:0] ACT_FRESH  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_RESUME = 3'd1;
	localparam logic [ACT_W-1:0] ACT_EDGE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] STAT_SAT   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEG    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd3;

	typedef struct packed {
		logic                      queued;
		logic [INV_W-1:0]          inv;
		logic [EIDX_W-1:0]         first;
		logic [CNT_W-1:0]          count;
		logic signed [VALUE_W-1:0] est;
		logic signed [VALUE_W-1:0] res;
	} vword_t;

	localparam int VWORD_W = $bits(vword_t);
endpackage
`default_nettype wire

>>> src/ppr_forward_push_engine.sv
// Forward push engine: a load goes through S_VRD and S_OUT to the output register, edge
// loads and rejected items through S_OUT alone. A push run is paced by the vertex
// memory read-modify-write and the three-step multiplier.
// Items are worked one at a time; a new item is taken while a result waits.
// After reset a clearing pass zeroes all 1024 words of the vertex memory; no item is
// taken meanwhile, configuration writes are.
`default_nettype none
module ppr_forward_push_engine (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [ppr_pkg::ACT_W-1:0]           action,
	input  wire logic [ppr_pkg::VIDX_W-1:0]          vertex,
	input  wire logic [ppr_pkg::VIDX_W-1:0]          neighbor_vertex,
	input  wire logic [ppr_pkg::EIDX_W-1:0]          edge_slot,
	input  wire logic [ppr_pkg::EIDX_W-1:0]          edge_first,
	input  wire logic [ppr_pkg::CNT_W-1:0]           edge_count,
	input  wire logic [ppr_pkg::INV_W-1:0]           inv_sqrt_degree,
	input  wire logic signed [ppr_pkg::VALUE_W-1:0]  residue_in,
	input  wire logic signed [ppr_pkg::VALUE_W-1:0]  estimate_in,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [ppr_pkg::VIDX_W-1:0]               vertex_out,
	output logic signed [ppr_pkg::VALUE_W-1:0]       estimate_out,
	output logic signed [ppr_pkg::VALUE_W-1:0]       residue_out,
	output logic [ppr_pkg::POPS_W-1:0]               pops_done,
	output logic [ppr_pkg::STAT_W-1:0]               status,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ppr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ppr_pkg::VALUE_W-1:0]         cfg_data
);
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_VRD   = 4'd2;
	localparam logic [3:0] S_OUT   = 4'd3;
	localparam logic [3:0] S_POP   = 4'd4;
	localparam logic [3:0] S_POPW  = 4'd5;
	localparam logic [3:0] S_TRD   = 4'd6;
	localparam logic [3:0] S_TSC   = 4'd7;
	localparam logic [3:0] S_EDGE  = 4'd8;
	localparam logic [3:0] S_NRD   = 4'd9;
	localparam logic [3:0] S_VRD2  = 4'd10;
	localparam logic [3:0] S_COEF  = 4'd11;
	localparam logic [3:0] S_ESC   = 4'd12;

	function automatic logic [ppr_pkg::VALUE_W:0] sat_add(
		input logic [ppr_pkg::VALUE_W-1:0] a,
		input logic [ppr_pkg::VALUE_W-1:0] b
	);
		logic [ppr_pkg::VALUE_W:0] s;
		s = {a[ppr_pkg::VALUE_W-1], a} + {b[ppr_pkg::VALUE_W-1], b};
		if (s[ppr_pkg::VALUE_W] != s[ppr_pkg::VALUE_W-1]) begin
			return {1'b1, s[ppr_pkg::VALUE_W] ? ppr_pkg::VMIN : ppr_pkg::VMAX};
		end
		return {1'b0, s[ppr_pkg::VALUE_W-1:0]};
	endfunction

	function automatic logic beyond(
		input logic signed [ppr_pkg::VALUE_W-1:0] r,
		input logic [ppr_pkg::POS_W-1:0]          pos,
		input logic signed [ppr_pkg::VALUE_W-1:0] neg
	);
		logic signed [ppr_pkg::VALUE_W-1:0] p;
		logic signed [ppr_pkg::VALUE_W-1:0] n;
		p = $signed({1'b0, pos});
		n = (neg == '0) ? -p : neg;
		return (r > p) || (r < n);
	endfunction

	// configuration
	logic [ppr_pkg::INV_W-1:0]          cfg_alpha_q;
	logic [ppr_pkg::POS_W-1:0]          cfg_pos_q;
	logic signed [ppr_pkg::VALUE_W-1:0] cfg_neg_q;
	logic [ppr_pkg::CNT_W-1:0]          cfg_active_q;

	logic [3:0]                         state_q;
	logic [ppr_pkg::VIDX_W-1:0]         clr_addr_q;
	logic [ppr_pkg::VIDX_W-1:0]         q_head_q, q_tail_q;
	logic [ppr_pkg::CNT_W-1:0]          q_count_q;
	logic [ppr_pkg::RUNP_W-1:0]         pops_q, last_pops_q;
	logic                               sat_q;

	// captured item
	logic [ppr_pkg::ACT_W-1:0]          act_q;
	logic [ppr_pkg::VIDX_W-1:0]         vtx_q;
	logic [ppr_pkg::EIDX_W-1:0]         first_q;
	logic [ppr_pkg::CNT_W-1:0]          count_q;
	logic [ppr_pkg::INV_W-1:0]          inv_q;
	logic signed [ppr_pkg::VALUE_W-1:0] res_q, est_q;

	// push working registers
	logic [ppr_pkg::VIDX_W-1:0]         t_q, v_q;
	ppr_pkg::vword_t                    tw_q, vw_q;
	logic signed [ppr_pkg::VALUE_W-1:0] old_q;
	logic [ppr_pkg::C_W-1:0]            c_q;
	logic [ppr_pkg::COEF_W-1:0]         coef_q;
	logic [ppr_pkg::SLOT_W-1:0]         slot_q;
	logic [ppr_pkg::CNT_W-1:0]          rem_q;

	// staged result and output register
	logic [ppr_pkg::VIDX_W-1:0]         r_vout_q;
	logic signed [ppr_pkg::VALUE_W-1:0] r_est_q, r_res_q;
	logic [ppr_pkg::STAT_W-1:0]         r_stat_q;
	logic                               out_valid_q;

	logic [ppr_pkg::CNT_W-1:0]          lim;
	logic [ppr_pkg::INV_W-1:0]          alpha_eff;
	logic                               accept, out_free;

	logic                               v_we;
	logic [ppr_pkg::VIDX_W-1:0]         v_waddr, v_raddr;
	ppr_pkg::vword_t                    v_wdata, vw_rd;
	logic [ppr_pkg::VWORD_W-1:0]        v_rdata;
	logic                               n_we;
	logic [ppr_pkg::VIDX_W-1:0]         n_rdata;
	logic                               q_we;
	logic [ppr_pkg::VIDX_W-1:0]         q_wdata, q_rdata;

	logic                               sc_start, sc_wide, sc_done, sc_ovf;
	logic signed [ppr_pkg::VALUE_W-1:0] sc_value, sc_result;
	logic [ppr_pkg::COEF_W-1:0]         sc_coef;

	logic [ppr_pkg::VALUE_W:0]          est_add, res_add;
	logic                               q_room, pop;

	assign lim = (cfg_active_q < ppr_pkg::CNT_W'(ppr_pkg::VERTICES)) ?
		cfg_active_q : ppr_pkg::CNT_W'(ppr_pkg::VERTICES);
	assign alpha_eff = (cfg_alpha_q > ppr_pkg::INV_W'(ppr_pkg::ONE_Q16)) ?
		ppr_pkg::INV_W'(ppr_pkg::ONE_Q16) : cfg_alpha_q;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign vw_rd     = ppr_pkg::vword_t'(v_rdata);
	assign q_room    = (q_count_q < ppr_pkg::CNT_W'(ppr_pkg::VERTICES));
	assign pop       = (state_q == S_POP) && (q_count_q != '0) &&
		(pops_q != ppr_pkg::RUNP_W'(ppr_pkg::POP_LIMIT));

	assign sc_start = (state_q == S_TRD) || (state_q == S_COEF);
	assign sc_wide  = (state_q == S_COEF);
	assign sc_value = (state_q == S_TRD) ? vw_rd.res : old_q;
	assign sc_coef  = (state_q == S_TRD) ? ppr_pkg::COEF_W'(alpha_eff) : coef_q;

	assign est_add = sat_add(tw_q.est, sc_result);
	assign res_add = sat_add(vw_q.res, sc_result);

	assign n_we = accept && (action == ppr_pkg::ACT_EDGE) && ({1'b0, neighbor_vertex} < lim) &&
		({1'b0, edge_slot} < ppr_pkg::SLOT_W'(ppr_pkg::EDGES));

	always_comb begin
		unique case (state_q)
			S_IDLE:  v_raddr = vertex;
			S_POPW:  v_raddr = q_rdata;
			S_NRD:   v_raddr = n_rdata;
			default: v_raddr = t_q;
		endcase
	end

	// vertex and queue memory writes
	always_comb begin
		v_we    = 1'b0;
		v_waddr = t_q;
		v_wdata = '0;
		q_we    = 1'b0;
		q_wdata = vtx_q;
		unique case (state_q)
			S_CLEAR: begin
				v_we    = 1'b1;
				v_waddr = clr_addr_q;
			end
			S_VRD: begin
				if (act_q != ppr_pkg::ACT_READ) begin
					q_we          = !vw_rd.queued && q_room &&
						beyond(res_q, cfg_pos_q, cfg_neg_q);
					v_we          = 1'b1;
					v_waddr       = vtx_q;
					v_wdata.queued = vw_rd.queued || q_we;
					v_wdata.inv   = inv_q;
					v_wdata.first = first_q;
					v_wdata.count = count_q;
					v_wdata.est   = (act_q == ppr_pkg::ACT_FRESH) ? '0 : est_q;
					v_wdata.res   = res_q;
				end
			end
			S_TSC: begin
				if (sc_done) begin
					v_we           = 1'b1;
					v_waddr        = t_q;
					v_wdata        = tw_q;
					v_wdata.queued = 1'b0;
					v_wdata.res    = '0;
					v_wdata.est    = est_add[ppr_pkg::VALUE_W-1:0];
				end
			end
			S_ESC: begin
				if (sc_done) begin
					q_we           = !vw_q.queued && q_room &&
						beyond(res_add[ppr_pkg::VALUE_W-1:0], cfg_pos_q, cfg_neg_q);
					q_wdata        = v_q;
					v_we           = 1'b1;
					v_waddr        = v_q;
					v_wdata        = vw_q;
					v_wdata.queued = vw_q.queued || q_we;
					v_wdata.res    = res_add[ppr_pkg::VALUE_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	ppr_ram #(.WIDTH(ppr_pkg::VWORD_W), .DEPTH(ppr_pkg::VERTICES)) u_vertex_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	ppr_ram #(.WIDTH(ppr_pkg::VIDX_W), .DEPTH(ppr_pkg::EDGES)) u_neighbor_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (edge_slot),
		.wdata (neighbor_vertex),
		.raddr (slot_q[ppr_pkg::EIDX_W-1:0]),
		.rdata (n_rdata)
	);

	ppr_ram #(.WIDTH(ppr_pkg::VIDX_W), .DEPTH(ppr_pkg::VERTICES)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_tail_q),
		.wdata (q_wdata),
		.raddr (q_head_q),
		.rdata (q_rdata)
	);

	ppr_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.value  (sc_value),
		.coef   (sc_coef),
		.wide   (sc_wide),
		.done   (sc_done),
		.result (sc_result),
		.ovf    (sc_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_alpha_q  <= ppr_pkg::INV_W'(6554);
			cfg_pos_q    <= '0;
			cfg_neg_q    <= '0;
			cfg_active_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ppr_pkg::CFG_ALPHA:  cfg_alpha_q  <= cfg_data[ppr_pkg::INV_W-1:0];
				ppr_pkg::CFG_POS:    cfg_pos_q    <= cfg_data[ppr_pkg::POS_W-1:0];
				ppr_pkg::CFG_NEG:    cfg_neg_q    <= cfg_data;
				ppr_pkg::CFG_ACTIVE: cfg_active_q <= cfg_data[ppr_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head_q  <= '0;
			q_tail_q  <= '0;
			q_count_q <= '0;
		end else begin
			if (q_we) begin
				q_tail_q <= (q_tail_q == ppr_pkg::VIDX_W'(ppr_pkg::VERTICES - 1)) ?
					'0 : q_tail_q + 1'b1;
			end
			if (pop) begin
				q_head_q <= (q_head_q == ppr_pkg::VIDX_W'(ppr_pkg::VERTICES - 1)) ?
					'0 : q_head_q + 1'b1;
			end
			q_count_q <= q_count_q + ppr_pkg::CNT_W'(q_we) - ppr_pkg::CNT_W'(pop);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			pops_q      <= '0;
			last_pops_q <= '0;
			sat_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ppr_pkg::VIDX_W'(ppr_pkg::VERTICES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (action) inside
							ppr_pkg::ACT_FRESH, ppr_pkg::ACT_RESUME, ppr_pkg::ACT_READ: begin
								state_q <= ({1'b0, vertex} < lim) ? S_VRD : S_OUT;
							end
							ppr_pkg::ACT_PUSH: begin
								pops_q  <= '0;
								sat_q   <= 1'b0;
								state_q <= S_POP;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_VRD:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					if (pop) begin
						pops_q  <= pops_q + 1'b1;
						state_q <= S_POPW;
					end else begin
						last_pops_q <= pops_q;
						state_q     <= S_OUT;
					end
				end
				S_POPW: state_q <= S_TRD;
				S_TRD:  state_q <= S_TSC;
				S_TSC: begin
					if (sc_done) begin
						sat_q   <= sat_q || sc_ovf || est_add[ppr_pkg::VALUE_W];
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					// drop the rest of a slice that runs past the store
					if (rem_q == '0 || slot_q >= ppr_pkg::SLOT_W'(ppr_pkg::EDGES)) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_NRD;
					end
				end
				S_NRD:  state_q <= ({1'b0, n_rdata} < lim) ? S_VRD2 : S_EDGE;
				S_VRD2: state_q <= S_COEF;
				S_COEF: state_q <= S_ESC;
				S_ESC: begin
					if (sc_done) begin
						sat_q   <= sat_q || sc_ovf || res_add[ppr_pkg::VALUE_W];
						state_q <= S_EDGE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q   <= action;
				vtx_q   <= vertex;
				first_q <= edge_first;
				count_q <= edge_count;
				inv_q   <= (inv_sqrt_degree > ppr_pkg::INV_W'(ppr_pkg::ONE_Q16)) ?
					ppr_pkg::INV_W'(ppr_pkg::ONE_Q16) : inv_sqrt_degree;
				res_q   <= residue_in;
				est_q   <= estimate_in;
				r_est_q <= '0;
				r_res_q <= '0;
				unique case (action) inside
					ppr_pkg::ACT_FRESH, ppr_pkg::ACT_RESUME, ppr_pkg::ACT_READ: begin
						r_vout_q <= vertex;
						r_stat_q <= ppr_pkg::STAT_RANGE;
					end
					ppr_pkg::ACT_EDGE: begin
						r_vout_q <= vertex;
						r_stat_q <= n_we ? ppr_pkg::STAT_OK : ppr_pkg::STAT_RANGE;
					end
					default: begin
						r_vout_q <= '0;
						r_stat_q <= ppr_pkg::STAT_RANGE;
					end
				endcase
			end
			S_VRD: begin
				r_stat_q <= ppr_pkg::STAT_OK;
				if (act_q == ppr_pkg::ACT_READ) begin
					r_est_q <= vw_rd.est;
					r_res_q <= vw_rd.res;
				end
			end
			S_POP: begin
				if (!pop) begin
					r_stat_q <= sat_q ? ppr_pkg::STAT_SAT : ppr_pkg::STAT_DONE;
				end
			end
			S_POPW: t_q <= q_rdata;
			S_TRD: begin
				tw_q  <= vw_rd;
				old_q <= vw_rd.res;
				c_q   <= (ppr_pkg::INV_W'(ppr_pkg::ONE_Q16) - alpha_eff) * vw_rd.inv;
			end
			S_TSC: begin
				slot_q <= {1'b0, tw_q.first};
				rem_q  <= tw_q.count;
			end
			S_EDGE: begin
				slot_q <= slot_q + 1'b1;
				rem_q  <= rem_q - 1'b1;
			end
			S_NRD: v_q <= n_rdata;
			S_VRD2: begin
				vw_q   <= vw_rd;
				coef_q <= c_q * vw_rd.inv;
			end
			S_ESC: begin
				if (sc_done) begin
					vw_q.res <= res_add[ppr_pkg::VALUE_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			vertex_out   <= r_vout_q;
			estimate_out <= r_est_q;
			residue_out  <= r_res_q;
			pops_done    <= ppr_pkg::POPS_W'(last_pops_q);
			status       <= r_stat_q;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

>>> src/ppr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none
module ppr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> src/ppr_scale.sv
// Three-step signed-by-unsigned scaler: magnitude times coefficient, shifted, clamped.
// Depends on ppr_pkg.
`default_nettype none
module ppr_scale (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [ppr_pkg::VALUE_W-1:0]  value,
	input  wire logic [ppr_pkg::COEF_W-1:0]          coef,
	input  wire logic                                wide,
	output logic                                     done,
	output logic signed [ppr_pkg::VALUE_W-1:0]       result,
	output logic                                     ovf
);
	localparam int PROD_W = ppr_pkg::VALUE_W + ppr_pkg::COEF_W;
	localparam int PART_W = ppr_pkg::VALUE_W + ppr_pkg::PIECE_W;

	logic [PROD_W-1:0]           acc_q;
	logic [ppr_pkg::VALUE_W-1:0] mag_q;
	logic [ppr_pkg::COEF_W-1:0]  coef_q;
	logic                        neg_q, wide_q, busy_q, done_q;
	logic [1:0]                  step_q;
	logic [ppr_pkg::PIECE_W-1:0] piece;
	logic [PART_W-1:0]           part;
	logic [PROD_W-1:0]           shifted;
	logic [ppr_pkg::POS_W-1:0]   mag_r;

	always_comb begin
		case (step_q)
			2'd0:    piece = coef_q[0 +: ppr_pkg::PIECE_W];
			2'd1:    piece = coef_q[ppr_pkg::PIECE_W +: ppr_pkg::PIECE_W];
			default: piece = coef_q[2*ppr_pkg::PIECE_W +: ppr_pkg::PIECE_W];
		endcase
		part = mag_q * piece;
		case (step_q)
			2'd0:    shifted = PROD_W'(part);
			2'd1:    shifted = PROD_W'(part) << ppr_pkg::PIECE_W;
			default: shifted = PROD_W'(part) << (2 * ppr_pkg::PIECE_W);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			mag_q  <= value[ppr_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
			neg_q  <= value[ppr_pkg::VALUE_W-1];
			coef_q <= coef;
			wide_q <= wide;
		end else if (busy_q) begin
			acc_q <= acc_q + shifted;
		end
	end

	always_comb begin
		if (wide_q) begin
			ovf   = |acc_q[PROD_W-1:ppr_pkg::EDGE_SH+ppr_pkg::POS_W];
			mag_r = acc_q[ppr_pkg::EDGE_SH +: ppr_pkg::POS_W];
		end else begin
			ovf   = |acc_q[PROD_W-1:ppr_pkg::ALPHA_SH+ppr_pkg::POS_W];
			mag_r = acc_q[ppr_pkg::ALPHA_SH +: ppr_pkg::POS_W];
		end
		if (ovf) begin
			result = neg_q ? ppr_pkg::VMIN : ppr_pkg::VMAX;
		end else begin
			result = neg_q ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
		end
	end

	assign done = done_q;
endmodule
`default_nettype wire

>>> src/ppr_chk.sv
// Port-level checker of the forward push engine, bound to the top level.
// Depends on ppr_pkg and ppr_forward_push_engine_defines.svh.
`default_nettype none
`include "ppr_forward_push_engine_defines.svh"
module ppr_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic [ppr_pkg::VIDX_W-1:0]         vertex_out,
	input wire logic signed [ppr_pkg::VALUE_W-1:0] estimate_out,
	input wire logic signed [ppr_pkg::VALUE_W-1:0] residue_out,
	input wire logic [ppr_pkg::STAT_W-1:0]         status
);
	`PPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`PPR_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second transfer taken during work")
	`PPR_ASSERT_NOW(a_push_no_vertex, out_valid && status == ppr_pkg::STAT_DONE, vertex_out == '0, "push result names a vertex")
	`PPR_ASSERT_NOW(a_values_only_ok, out_valid && status != ppr_pkg::STAT_OK, estimate_out == '0 && residue_out == '0, "values on a failed result")
endmodule

bind ppr_forward_push_engine ppr_chk u_ppr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.vertex_out   (vertex_out),
	.estimate_out (estimate_out),
	.residue_out  (residue_out),
	.status       (status)
);
`default_nettype wire
